[src/tht_pkg.sv]
package tht_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam logic [7:0] FLAG_SYN    = 8'd2;
    localparam logic [7:0] FLAG_SYNACK = 8'd18;
    localparam logic [7:0] FLAG_ACK    = 8'd16;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_MARK   = 1'b1;

    // Bit positions within the per-session progress field.
    localparam int PROG_ANSWERED = 0;
    localparam int PROG_ACKED    = 1;
    localparam int PROG_REPORTED = 2;

    typedef enum logic [2:0] {
        EV_IGNORED   = 3'd0,
        EV_INSERTED  = 3'd1,
        EV_DUPLICATE = 3'd2,
        EV_FULL      = 3'd3,
        EV_SYNACK    = 3'd4,
        EV_DONE      = 3'd5,
        EV_NOMATCH   = 3'd6,
        EV_MARKED    = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] ports;
    } t_key;

    typedef struct packed {
        logic       valid;
        logic [2:0] prog;
    } t_slot;

    typedef struct packed {
        logic rd_en;
        logic st_we;
        logic key_we;
    } t_tbl_ctl;

endpackage

[src/tht_if.sv]
interface tht_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;

    modport source (output valid, action, src_ip, dst_ip, src_port, dst_port, tcp_flags,
                    input ready);
    modport sink (input valid, action, src_ip, dst_ip, src_port, dst_port, tcp_flags,
                  output ready);
endinterface

interface tht_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       entry_found;
    logic [5:0] entry_index;

    modport source (output valid, event_code, entry_found, entry_index, input ready);
    modport sink (input valid, event_code, entry_found, entry_index, output ready);
endinterface

[src/tht_table.sv]
module tht_table
    import tht_pkg::*;
#(
    parameter int SESSION_SLOTS = SLOTS_DEFAULT,
    parameter int IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1
) (
    input  logic             i_clk,
    input  t_tbl_ctl         i_ctl,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_slot            i_wr_slot,
    input  t_key             i_wr_key,
    output t_slot            o_rd_slot,
    output t_key             o_rd_key
);

    t_key  mem_key [SESSION_SLOTS];
    t_slot mem_st  [SESSION_SLOTS];

    t_key  r_rd_key;
    t_slot r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            mem_st[i_wr_addr] <= i_wr_slot;
        end
        if (i_ctl.key_we) begin
            mem_key[i_wr_addr] <= i_wr_key;
        end
        if (i_ctl.rd_en) begin
            r_rd_slot <= mem_st[i_rd_addr];
            r_rd_key  <= mem_key[i_rd_addr];
        end
    end

    assign o_rd_slot = r_rd_slot;
    assign o_rd_key  = r_rd_key;

endmodule

[src/tht_ctrl.sv]
module tht_ctrl
    import tht_pkg::*;
#(
    parameter int SESSION_SLOTS = SLOTS_DEFAULT,
    parameter int IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tht_in_if.sink           i_in,
    tht_out_if.source        o_out,
    output t_tbl_ctl         o_ctl,
    output logic [IDX_W-1:0] o_rd_addr,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_slot            o_wr_slot,
    output t_key             o_wr_key,
    input  t_slot            i_rd_slot,
    input  t_key             i_rd_key
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSION_SLOTS - 1);

    t_state r_state, n_state;

    logic [IDX_W-1:0] r_cnt;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    logic             r_act;
    logic [7:0]       r_flags;
    t_key             r_key;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [2:0]       r_hit_prog;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_out_vld;
    t_event           r_out_code;
    logic             r_out_found;
    logic [5:0]       r_out_idx;

    logic             in_fire;
    logic             out_free;
    logic             cnt_last;
    logic             m_hit;

    t_event           d_code;
    logic             d_found;
    logic [IDX_W-1:0] d_slot;
    logic             d_st_we;
    logic             d_key_we;
    t_slot            d_slot_val;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign cnt_last = (r_cnt == LAST_IDX);
    assign m_hit    = r_cmp_vld && i_rd_slot.valid && (i_rd_key == r_key);

    // Outcome of one item, from the scan summary and the latched header.
    always_comb begin
        d_code     = EV_IGNORED;
        d_found    = 1'b0;
        d_slot     = r_hit_idx;
        d_st_we    = 1'b0;
        d_key_we   = 1'b0;
        d_slot_val = '{valid: 1'b1, prog: r_hit_prog};
        if (r_act == ACT_MARK) begin
            if (r_hit) begin
                d_code                    = EV_MARKED;
                d_found                   = 1'b1;
                d_st_we                   = 1'b1;
                d_slot_val.prog[PROG_REPORTED] = 1'b1;
            end else begin
                d_code = EV_NOMATCH;
            end
        end else if (r_flags == FLAG_SYN) begin
            if (r_hit) begin
                d_code  = EV_DUPLICATE;
                d_found = 1'b1;
            end else if (r_free) begin
                d_code          = EV_INSERTED;
                d_found         = 1'b1;
                d_slot          = r_free_idx;
                d_st_we         = 1'b1;
                d_key_we        = 1'b1;
                d_slot_val.prog = '0;
            end else begin
                d_code = EV_FULL;
            end
        end else if (r_flags == FLAG_SYNACK) begin
            if (r_hit) begin
                d_code                         = EV_SYNACK;
                d_found                        = 1'b1;
                d_st_we                        = 1'b1;
                d_slot_val.prog[PROG_ANSWERED] = 1'b1;
            end else begin
                d_code = EV_NOMATCH;
            end
        end else if (r_flags == FLAG_ACK) begin
            if (r_hit) begin
                d_found = 1'b1;
                if (r_hit_prog[PROG_ANSWERED] && !r_hit_prog[PROG_REPORTED]) begin
                    d_code                      = EV_DONE;
                    d_st_we                     = 1'b1;
                    d_slot_val.prog[PROG_ACKED] = 1'b1;
                end
            end else begin
                d_code = EV_NOMATCH;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (cnt_last) n_state = ST_LAST;
            end
            ST_LAST: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        i_in.ready   = 1'b0;
        o_ctl        = '0;
        o_rd_addr    = r_cnt;
        o_wr_addr    = d_slot;
        o_wr_slot    = d_slot_val;
        o_wr_key     = r_key;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.st_we = 1'b1;
                o_wr_addr   = r_cnt;
                o_wr_slot   = '0;
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_SCAN: begin
                o_ctl.rd_en = 1'b1;
            end
            ST_LAST: begin
                o_ctl = '0;
            end
            ST_DECIDE: begin
                o_ctl.st_we  = d_st_we && out_free;
                o_ctl.key_we = d_key_we && out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
                r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
            end
            if (r_state == ST_DECIDE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
        if (in_fire) begin
            r_act   <= i_in.action;
            r_flags <= i_in.tcp_flags;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            // A SYN/ACK travels the other way, so it looks up the reversed key.
            if (i_in.action == ACT_PACKET && i_in.tcp_flags == FLAG_SYNACK) begin
                r_key.addr  <= {i_in.dst_ip, i_in.src_ip};
                r_key.ports <= {i_in.dst_port, i_in.src_port};
            end else begin
                r_key.addr  <= {i_in.src_ip, i_in.dst_ip};
                r_key.ports <= {i_in.src_port, i_in.dst_port};
            end
        end else if (r_cmp_vld) begin
            if (m_hit && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_prog <= i_rd_slot.prog;
            end
            if (!i_rd_slot.valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        if (r_state == ST_DECIDE && out_free) begin
            r_out_code  <= d_code;
            r_out_found <= d_found;
            r_out_idx   <= d_found ? 6'(d_slot) : 6'd0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.event_code  = r_out_code;
    assign o_out.entry_found = r_out_found;
    assign o_out.entry_index = r_out_idx;

`ifndef SYNTH
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_LAST) |-> !(o_ctl.st_we || o_ctl.key_we))
        else $error("table written during a scan");

    a_key_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.key_we |-> (o_ctl.st_we && o_wr_slot.valid))
        else $error("key written without marking the slot valid");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_SCAN && r_cnt == '0))
        else $error("accepted word did not start a scan at slot zero");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_DECIDE))
        else $error("result appeared outside the decide step");

    a_found_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_found) |-> (r_out_idx == 6'd0))
        else $error("nonzero index on a result without a session");
`endif

endmodule

[src/tcp_handshake_tracker.sv]
// Tracks TCP three-way handshakes in a table of SESSION_SLOTS sessions held in
// two single-port-read memories (keys and per-slot progress). Every word, a packet
// header or a consumer mark, scans all slots once through the memory read port, one
// slot per cycle, then writes back at most one slot, and no new word is accepted
// until the block is through with the last one. A result waits in an output register
// and the scan pipeline holds in its final step while that register is full and the
// result is not being taken. After reset the block clears the progress memory in a
// pass over every slot and accepts no word until it ends.
module tcp_handshake_tracker
    import tht_pkg::*;
#(
    parameter int SESSION_SLOTS = SLOTS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tht_in_if.sink    i_in,
    tht_out_if.source o_out
);

    localparam int IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

    t_tbl_ctl         tbl_ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_slot;
    t_key             wr_key;
    t_slot            rd_slot;
    t_key             rd_key;

    tht_ctrl #(
        .SESSION_SLOTS(SESSION_SLOTS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_ctl    (tbl_ctl),
        .o_rd_addr(rd_addr),
        .o_wr_addr(wr_addr),
        .o_wr_slot(wr_slot),
        .o_wr_key (wr_key),
        .i_rd_slot(rd_slot),
        .i_rd_key (rd_key)
    );

    tht_table #(
        .SESSION_SLOTS(SESSION_SLOTS),
        .IDX_W        (IDX_W)
    ) u_table (
        .i_clk    (i_clk),
        .i_ctl    (tbl_ctl),
        .i_rd_addr(rd_addr),
        .i_wr_addr(wr_addr),
        .i_wr_slot(wr_slot),
        .i_wr_key (wr_key),
        .o_rd_slot(rd_slot),
        .o_rd_key (rd_key)
    );

endmodule
